### src/lnds_pkg.sv
package lnds_pkg;

    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;
    localparam int STEP_W = 4;

    // datapath actions, one per microcode step
    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_SCAN,
        A_STORE,
        A_DROP,
        A_BACK_INIT,
        A_BACK,
        A_PICK_RD,
        A_EMIT,
        A_CLEAR
    } act_t;

    // jump conditions: jump to target when true, else fall through
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_XFER,
        C_FULL,
        C_SCAN_MORE,
        C_NOT_FINAL,
        C_BACK_MORE,
        C_OUT_BUSY,
        C_OUT_MORE
    } cond_t;

    typedef struct packed {
        act_t              act;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic in_xfer;
        logic full;
        logic final_item;
        logic scan_more;
        logic back_more;
        logic out_busy;
        logic out_more;
    } dp_status_t;

    localparam logic [STEP_W-1:0] ST_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] ST_CHECK     = 4'd1;
    localparam logic [STEP_W-1:0] ST_SCAN      = 4'd2;
    localparam logic [STEP_W-1:0] ST_STORE     = 4'd3;
    localparam logic [STEP_W-1:0] ST_TO_BACK   = 4'd4;
    localparam logic [STEP_W-1:0] ST_DROP      = 4'd5;
    localparam logic [STEP_W-1:0] ST_BACK_INIT = 4'd6;
    localparam logic [STEP_W-1:0] ST_BACK      = 4'd7;
    localparam logic [STEP_W-1:0] ST_PICK_RD   = 4'd8;
    localparam logic [STEP_W-1:0] ST_EMIT      = 4'd9;
    localparam logic [STEP_W-1:0] ST_EMIT_NEXT = 4'd10;
    localparam logic [STEP_W-1:0] ST_CLEAR     = 4'd11;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            ST_IDLE:      w = '{A_ACCEPT,    C_NO_XFER,   ST_IDLE};
            ST_CHECK:     w = '{A_NONE,      C_FULL,      ST_DROP};
            ST_SCAN:      w = '{A_SCAN,      C_SCAN_MORE, ST_SCAN};
            ST_STORE:     w = '{A_STORE,     C_NOT_FINAL, ST_IDLE};
            ST_TO_BACK:   w = '{A_NONE,      C_ALWAYS,    ST_BACK_INIT};
            ST_DROP:      w = '{A_DROP,      C_NOT_FINAL, ST_IDLE};
            ST_BACK_INIT: w = '{A_BACK_INIT, C_NEXT,      ST_IDLE};
            ST_BACK:      w = '{A_BACK,      C_BACK_MORE, ST_BACK};
            ST_PICK_RD:   w = '{A_PICK_RD,   C_NEXT,      ST_IDLE};
            ST_EMIT:      w = '{A_EMIT,      C_OUT_BUSY,  ST_EMIT};
            ST_EMIT_NEXT: w = '{A_NONE,      C_OUT_MORE,  ST_PICK_RD};
            ST_CLEAR:     w = '{A_CLEAR,     C_ALWAYS,    ST_IDLE};
            default:      w = '{A_NONE,      C_ALWAYS,    ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

### src/lnds_seq.sv
module lnds_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lnds_pkg::dp_status_t  status,
    output lnds_pkg::act_t        act
);
    import lnds_pkg::*;

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    ucode_t            word;
    logic              take_jump;

    assign word = ucode_rom(pc_reg);
    assign act  = word.act;

    always_comb begin
        case (word.cond)
            C_NEXT:      take_jump = 1'b0;
            C_ALWAYS:    take_jump = 1'b1;
            C_NO_XFER:   take_jump = !status.in_xfer;
            C_FULL:      take_jump = status.full;
            C_SCAN_MORE: take_jump = status.scan_more;
            C_NOT_FINAL: take_jump = !status.final_item;
            C_BACK_MORE: take_jump = status.back_more;
            C_OUT_BUSY:  take_jump = status.out_busy;
            C_OUT_MORE:  take_jump = status.out_more;
            default:     take_jump = 1'b1;
        endcase
        pc_next = take_jump ? word.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ST_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

### src/lnds_dp.sv
module lnds_dp #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lnds_pkg::act_t        act,
    output lnds_pkg::dp_status_t  status,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);
    import lnds_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic signed [DATA_W-1:0] val_mem  [MAX_ITEMS];
    logic        [LEN_W-1:0]  len_mem  [MAX_ITEMS];
    logic signed [DATA_W-1:0] pick_mem [MAX_ITEMS];

    logic [CW-1:0]            n_reg, n_next;
    logic                     ovf_reg, ovf_next;
    logic [LEN_W-1:0]         top_reg, top_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [LEN_W-1:0]         want_reg, want_next;
    logic [LEN_W-1:0]         oidx_reg, oidx_next;
    logic [LEN_W-1:0]         best_reg, best_next;
    logic signed [DATA_W-1:0] v_reg, v_next;
    logic                     final_reg, final_next;
    logic                     rdv_reg, rdv_next;
    logic signed [DATA_W-1:0] val_q;
    logic [LEN_W-1:0]         len_q;
    logic signed [DATA_W-1:0] pick_q;

    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_elem_reg;
    logic [LEN_W-1:0]         m_len_reg;
    logic                     m_ovf_reg;
    logic                     m_last_reg;

    logic                     in_xfer;
    logic                     issue_scan, issue_back, issue_rd;
    logic [CW-1:0]            idx_m1;
    logic [AW-1:0]            rd_addr;
    logic [LEN_W-1:0]         want_m1;
    logic [LEN_W-1:0]         new_len;
    logic [LEN_W-1:0]         oidx_inc;
    logic                     hit_scan, hit_back;
    logic                     out_busy, load_out;

    assign s_tready   = (act == A_ACCEPT);
    assign in_xfer    = s_tready && s_tvalid;
    assign issue_scan = (act == A_SCAN) && (idx_reg < n_reg);
    assign issue_back = (act == A_BACK) && (idx_reg != '0);
    assign issue_rd   = issue_scan || issue_back;
    assign idx_m1     = idx_reg - 1'b1;
    assign rd_addr    = issue_back ? idx_m1[AW-1:0] : idx_reg[AW-1:0];
    assign want_m1    = want_reg - 1'b1;
    assign new_len    = best_reg + 1'b1;
    assign oidx_inc   = oidx_reg + 1'b1;

    // reads are registered, so the compare acts on the data in the cycle after the address issues
    assign hit_scan = (act == A_SCAN) && rdv_reg && (val_q <= v_reg) && (len_q > best_reg);
    assign hit_back = (act == A_BACK) && rdv_reg && (want_reg != '0) && (len_q == want_reg);

    assign out_busy = m_valid_reg && !m_tready;
    assign load_out = (act == A_EMIT) && !out_busy;

    assign status.in_xfer    = in_xfer;
    assign status.full       = (n_reg == CW'(MAX_ITEMS));
    assign status.final_item = final_reg;
    assign status.scan_more  = (idx_reg < n_reg);
    assign status.back_more  = (idx_reg != '0);
    assign status.out_busy   = out_busy;
    assign status.out_more   = (oidx_reg < top_reg);

    always_comb begin
        n_next     = n_reg;
        ovf_next   = ovf_reg;
        top_next   = top_reg;
        idx_next   = idx_reg;
        want_next  = want_reg;
        oidx_next  = oidx_reg;
        best_next  = best_reg;
        v_next     = v_reg;
        final_next = final_reg;
        rdv_next   = issue_rd;
        case (act)
            A_ACCEPT: begin
                if (in_xfer) begin
                    v_next     = s_tdata;
                    final_next = s_tlast;
                    idx_next   = '0;
                    best_next  = '0;
                end
            end
            A_SCAN: begin
                if (issue_scan) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (hit_scan) begin
                    best_next = len_q;
                end
            end
            A_STORE: begin
                n_next = n_reg + 1'b1;
                if (new_len > top_reg) begin
                    top_next = new_len;
                end
            end
            A_DROP: begin
                ovf_next = 1'b1;
            end
            A_BACK_INIT: begin
                idx_next  = n_reg;
                want_next = top_reg;
                oidx_next = '0;
            end
            A_BACK: begin
                if (issue_back) begin
                    idx_next = idx_m1;
                end
                if (hit_back) begin
                    want_next = want_m1;
                end
            end
            A_EMIT: begin
                if (load_out) begin
                    oidx_next = oidx_inc;
                end
            end
            A_CLEAR: begin
                n_next   = '0;
                ovf_next = 1'b0;
                top_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg       <= '0;
            ovf_reg     <= 1'b0;
            top_reg     <= '0;
            idx_reg     <= '0;
            want_reg    <= '0;
            oidx_reg    <= '0;
            best_reg    <= '0;
            final_reg   <= 1'b0;
            rdv_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            n_reg       <= n_next;
            ovf_reg     <= ovf_next;
            top_reg     <= top_next;
            idx_reg     <= idx_next;
            want_reg    <= want_next;
            oidx_reg    <= oidx_next;
            best_reg    <= best_next;
            final_reg   <= final_next;
            rdv_reg     <= rdv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg <= v_next;
        if (load_out) begin
            m_elem_reg <= pick_q;
            m_len_reg  <= top_reg;
            m_ovf_reg  <= ovf_reg;
            m_last_reg <= (oidx_inc == top_reg);
        end
    end

    // element and length stores, one shared read port
    always_ff @(posedge aclk) begin
        if (act == A_STORE) begin
            val_mem[n_reg[AW-1:0]] <= v_reg;
            len_mem[n_reg[AW-1:0]] <= new_len;
        end
        if (issue_rd) begin
            val_q <= val_mem[rd_addr];
            len_q <= len_mem[rd_addr];
        end
    end

    // picked elements land in sequence order
    always_ff @(posedge aclk) begin
        if (hit_back) begin
            pick_mem[want_m1[AW-1:0]] <= val_q;
        end
        if (act == A_PICK_RD) begin
            pick_q <= pick_mem[oidx_reg[AW-1:0]];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_len_reg, m_elem_reg};
    assign m_tuser  = m_ovf_reg;
    assign m_tlast  = m_last_reg;

endmodule

### src/longest_nondecreasing_subsequence_unit.sv
// Longest non-decreasing subsequence over a stream of signed 32-bit values. Each transfer on
// the s_ side brings one value, and s_tlast marks the last one of a sequence. Up to
// MAX_ITEMS values are kept; any beyond that are dropped and the run is flagged on m_tuser.
// On the last value the block emits one longest non-decreasing subsequence on the m_ side,
// in sequence order, with its length in every transfer and m_tlast on its final element.
// It then clears itself for the next sequence. A small microcode program steps a shared
// datapath that holds the element and length memories, which have one read port. For each
// value that is stored, every held value is read once; a value dropped for want of space
// skips that read. After a last value the block sets up and runs a backward pass over the
// held values, then emits the results one at a time, waiting while m_tready is low, before
// it clears.
// s_tready is high only when the block waits for the next value. It is not held back by a
// result still waiting in the output register.
module longest_nondecreasing_subsequence_unit #(
    parameter int MAX_ITEMS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] element, [38:32] subseq_length, [39] zero
    output logic        m_tuser,   // [0] overflowed
    output logic        m_tlast
);
    import lnds_pkg::*;

    act_t       act;
    dp_status_t status;

    lnds_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .act     (act)
    );

    lnds_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .act      (act),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### tb/longest_nondecreasing_subsequence_unit_tb.sv
`timescale 1ns / 1ps

import lnds_pkg::*;

typedef struct {
    logic [DATA_W-1:0] element;
    logic [LEN_W-1:0]  run_len;
    logic              ovf;
    logic              last;
} picked_elem_t;

typedef enum int {
    SEQ_WIDE,
    SEQ_NARROW,
    SEQ_RISING,
    SEQ_SORTED,
    SEQ_EXTREME
} seq_kind_t;

class lnds_scoreboard;
    localparam int CAP = 64;

    logic [DATA_W-1:0] held_vals [CAP];
    logic [LEN_W-1:0]  held_lens [CAP];
    int                held_cnt;
    bit                dropped;
    picked_elem_t      subseq_q [$];
    int                errors;

    function new();
        held_cnt = 0;
        dropped  = 0;
        errors   = 0;
    endfunction

    function int pending();
        return subseq_q.size();
    endfunction

    // store one value, or flag a drop when full, and on the last one queue the recovered subsequence
    function void note_input(logic [DATA_W-1:0] v, logic fin);
        logic [LEN_W-1:0]  best;
        logic [LEN_W-1:0]  top;
        logic [DATA_W-1:0] picked [CAP];
        int                want;
        picked_elem_t      e;
        if (held_cnt >= CAP) begin
            dropped = 1;
        end else begin
            best = '0;
            for (int j = 0; j < held_cnt; j++) begin
                if ($signed(held_vals[j]) <= $signed(v) && held_lens[j] > best)
                    best = held_lens[j];
            end
            held_vals[held_cnt] = v;
            held_lens[held_cnt] = best + 1'b1;
            held_cnt++;
        end
        if (!fin)
            return;
        top = '0;
        for (int i = 0; i < held_cnt; i++) begin
            if (held_lens[i] > top)
                top = held_lens[i];
        end
        // backward scan: latest element of each length
        want = int'(top);
        for (int i = held_cnt - 1; i >= 0 && want > 0; i--) begin
            if (int'(held_lens[i]) == want) begin
                want--;
                picked[want] = held_vals[i];
            end
        end
        for (int i = 0; i < int'(top); i++) begin
            e.element = picked[i];
            e.run_len = top;
            e.ovf     = dropped;
            e.last    = (i + 1 == int'(top));
            subseq_q.push_back(e);
        end
        held_cnt = 0;
        dropped  = 0;
    endfunction

    function void field_check(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_result(logic [DATA_W-1:0] element, logic [LEN_W-1:0] run_len,
                               logic ovf, logic last);
        picked_elem_t e;
        if (subseq_q.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, got element %0h",
                     $time, element);
            errors++;
            return;
        end
        e = subseq_q.pop_front();
        field_check("element", e.element, element);
        field_check("subseq_length", DATA_W'(e.run_len), DATA_W'(run_len));
        field_check("overflowed", DATA_W'(e.ovf), DATA_W'(ovf));
        field_check("last", DATA_W'(e.last), DATA_W'(last));
    endfunction
endclass

module longest_nondecreasing_subsequence_unit_tb;

    localparam int LIMIT     = 400000;
    localparam int HOLD_LEN  = 400;
    localparam int PHASE_LEN = 30;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] element, [38:32] subseq_length, [39] zero
    logic        m_tuser;   // [0] overflowed
    logic        m_tlast;

    lnds_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    bit             hold_req;
    bit             hold_done;
    int             hold_left;
    int             cycles;

    longest_nondecreasing_subsequence_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[31:0], m_tdata[38:32], m_tuser, m_tlast);
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        hold_done = 0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic offer_value(input logic [31:0] v, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_input(v, fin);
        @(negedge aclk);
    endtask

    task automatic send_sequence(input int len, input seq_kind_t kind);
        logic [31:0] v;
        logic [31:0] acc;
        acc = 32'h8000_0000 + $urandom_range(0, 3000) - 1500;
        for (int i = 0; i < len; i++) begin
            case (kind)
                SEQ_WIDE: begin
                    v = $urandom();
                end
                SEQ_NARROW: begin
                    v = $urandom_range(0, 6);
                    v = v - 32'd3;
                end
                SEQ_RISING: begin
                    acc = acc + $urandom_range(0, 1 << 28);
                    v   = ($urandom_range(0, 4) == 0) ? acc - $urandom_range(1, 1 << 29) : acc;
                end
                SEQ_SORTED: begin
                    acc = acc + $urandom_range(0, 2);
                    v   = acc;
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0: v = 32'h8000_0000;
                        1: v = 32'h7fff_ffff;
                        2: v = 32'h0000_0000;
                        3: v = 32'hffff_ffff;
                        default: v = $urandom();
                    endcase
                end
            endcase
            offer_value(v, i == len - 1);
        end
    endtask

    task automatic random_phase(input int budget);
        int sent;
        int len;
        sent = 0;
        while (sent < budget) begin
            len = $urandom_range(1, 10);
            send_sequence(len, seq_kind_t'($urandom_range(0, 4)));
            sent += len;
        end
    endtask

    initial begin
        sb             = new();
        hold_req       = 0;
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // single-element sequences at both extremes
        offer_value(32'h8000_0000, 1'b1);
        offer_value(32'h7fff_ffff, 1'b1);
        // extremes, equal values and sign crossing
        offer_value(32'h7fff_ffff, 1'b0);
        offer_value(32'h8000_0000, 1'b0);
        offer_value(32'h0000_0000, 1'b0);
        offer_value(32'h0000_0000, 1'b0);
        offer_value(32'hffff_ffff, 1'b0);
        offer_value(32'h7fff_ffff, 1'b1);
        // strictly falling: every element has length one, the latest wins
        offer_value(32'd5, 1'b0);
        offer_value(32'd4, 1'b0);
        offer_value(32'd3, 1'b0);
        offer_value(32'd2, 1'b1);
        // all equal
        offer_value(32'hffff_ffff, 1'b0);
        offer_value(32'hffff_ffff, 1'b0);
        offer_value(32'hffff_ffff, 1'b1);
        // alternating bit patterns
        offer_value(32'haaaa_aaaa, 1'b0);
        offer_value(32'h5555_5555, 1'b1);

        // no idling, with a long receiver hold-off so the block backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1;
        random_phase(PHASE_LEN);

        send_idle_pct  = 75;
        recv_stall_pct = 0;
        random_phase(PHASE_LEN);

        // full store, longest possible run, under heavy receiver stalls
        send_idle_pct  = 0;
        recv_stall_pct = 75;
        send_sequence(64, SEQ_SORTED);
        random_phase(PHASE_LEN);

        // store overflow, last value dropped
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        send_sequence($urandom_range(65, 67), seq_kind_t'($urandom_range(0, 4)));
        random_phase(PHASE_LEN);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
